### rtl/srx_pkg.sv
// ----------------------------------------------------------------------------
// srx_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the sensor
// frame receiver.
// ----------------------------------------------------------------------------
package srx_pkg;

  localparam int FRAME_LEN  = 21;
  localparam int CRC_LEN    = 19;
  localparam int LAST_IDX   = FRAME_LEN - 1;
  localparam int IDX_W      = $clog2(FRAME_LEN);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int OUT_DATA_W = 152;

  localparam logic [7:0]  SYNC_BYTE = 8'hFF;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(LAST_IDX);
  localparam logic [IDX_W-1:0] IDX_CRC_END = IDX_W'(CRC_LEN);

  // One frame byte handed from the front to the back
  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
  } item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Decoded frame, packed lowest field last so that it maps onto tdata
  typedef struct packed {
    logic [7:0]  firmware_version;
    logic [7:0]  motor_current;
    logic [31:0] right_odometry;
    logic [31:0] left_odometry;
    logic [7:0]  right_ir_b;
    logic [7:0]  right_ir_a;
    logic [7:0]  left_ir_b;
    logic [7:0]  left_ir_a;
    logic [7:0]  battery_voltage;
    logic [15:0] right_speed;
    logic [15:0] left_speed;
  } frame_fields_t;

  // Reflected CRC-16 update over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/srx_front.sv
// ----------------------------------------------------------------------------
// srx_front
// Hunts for the sync byte, then numbers the next frame bytes and pushes each
// one into the queue.
// ----------------------------------------------------------------------------
module srx_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  srx_pkg::queue_status_t q_status,
  output logic                  push,
  output srx_pkg::item_t        push_item
);
  import srx_pkg::*;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'b01,
    ST_COLLECT = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic             accept;

  // Accept whenever the queue has room, hunting bytes included
  assign s_tready = ~q_status.full;
  assign accept   = s_tvalid & s_tready;

  // Queue only the bytes that belong to a frame
  assign push            = accept & (state == ST_COLLECT);
  assign push_item.data  = s_tdata;
  assign push_item.index = byte_index;

  // Advance the hunt/collect state
  always_comb begin
    state_next      = state;
    byte_index_next = byte_index;
    if (accept) begin
      unique case (state)
        ST_HUNT: begin
          if (s_tdata == SYNC_BYTE) begin
            state_next      = ST_COLLECT;
            byte_index_next = '0;
          end
        end
        ST_COLLECT: begin
          if (byte_index == IDX_LAST) begin
            state_next      = ST_HUNT;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + 1'b1;
          end
        end
        default: begin
          state_next      = ST_HUNT;
          byte_index_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_HUNT;
      byte_index <= '0;
    end else begin
      state      <= state_next;
      byte_index <= byte_index_next;
    end
  end

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_LAST)
    else $error("frame index beyond last byte");

  a_hunt_index_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_HUNT |-> byte_index == '0)
    else $error("index not cleared while hunting");

  a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    push && push_item.index == IDX_LAST |=> state == ST_HUNT)
    else $error("no return to hunting after last frame byte");

endmodule

### rtl/srx_queue.sv
// ----------------------------------------------------------------------------
// srx_queue
// Short first-in first-out queue of frame bytes between front and back.
// ----------------------------------------------------------------------------
module srx_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  srx_pkg::item_t         push_item,
  input  logic                   pop,
  output srx_pkg::item_t         head,
  output srx_pkg::queue_status_t status
);
  import srx_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;

  // Store the incoming byte
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

### rtl/srx_back.sv
// ----------------------------------------------------------------------------
// srx_back
// Runs the CRC over frame bytes, keeps the frame, and on the last byte checks
// the CRC and loads the decoded result into the output register.
// ----------------------------------------------------------------------------
module srx_back (
  input  logic                            clk,
  input  logic                            rst,
  input  srx_pkg::queue_status_t          q_status,
  input  srx_pkg::item_t                  head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [srx_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser
);
  import srx_pkg::*;

  logic [7:0]    frame_bytes [LAST_IDX];
  logic [15:0]   crc;
  logic [15:0]   crc_next;
  logic          is_last;
  logic          out_free;
  logic          crc_ok;
  frame_fields_t fields;

  assign is_last  = (head.index == IDX_LAST);
  assign out_free = ~m_tvalid | m_tready;
  // Only the last byte needs room in the output register
  assign pop      = ~q_status.empty & (~is_last | out_free);

  // Restart the CRC on the first byte, stop after the covered span
  always_comb begin
    crc_next = crc;
    if (head.index == '0) begin
      crc_next = crc_feed(CRC_INIT, head.data);
    end else if (head.index < IDX_CRC_END) begin
      crc_next = crc_feed(crc, head.data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (pop) begin
      crc <= crc_next;
    end
  end

  // Hold frame bytes at their positions
  always_ff @(posedge clk) begin
    for (int i = 0; i < LAST_IDX; i++) begin
      if (pop && head.index == IDX_W'(i)) begin
        frame_bytes[i] <= head.data;
      end
    end
  end

  // Compare against the little-endian check word; last byte arrives now
  assign crc_ok = ({head.data, frame_bytes[LAST_IDX-1]} == crc);

  always_comb begin
    fields.left_speed       = {frame_bytes[1], frame_bytes[0]};
    fields.right_speed      = {frame_bytes[10], frame_bytes[9]};
    fields.battery_voltage  = frame_bytes[2];
    fields.left_ir_a        = frame_bytes[3];
    fields.left_ir_b        = frame_bytes[4];
    fields.right_ir_a       = frame_bytes[11];
    fields.right_ir_b       = frame_bytes[12];
    fields.left_odometry    = {frame_bytes[8], frame_bytes[7], frame_bytes[6], frame_bytes[5]};
    fields.right_odometry   = {frame_bytes[16], frame_bytes[15], frame_bytes[14],
                               frame_bytes[13]};
    fields.motor_current    = frame_bytes[17];
    fields.firmware_version = frame_bytes[18];
  end

  // Output register: load on the last byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && is_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_last) begin
      m_tdata <= crc_ok ? fields : '0;
      m_tuser <= ~crc_ok;
    end
  end

  a_bad_frame_zeroed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("fields not cleared on CRC mismatch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(pop && is_last))
    else $error("pending result overwritten");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    pop && is_last |=> m_tvalid)
    else $error("result not presented after last byte");

endmodule

### rtl/sensor_frame_receiver.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver
// Serial frame receiver: sync hunt, 21-byte frame capture, CRC-16/MODBUS
// check and sensor field decode.
//
//   Channel  Direction  Per transaction
//   s_*      in         one received byte (s_tdata[7:0] = rx_byte)
//   m_*      out        one decoded frame, status on m_tuser
//
// One byte is taken every cycle while the four-entry byte queue has room.
// With the queue otherwise empty, the last frame byte passes through a queue
// entry before the back loads the output register and raises m_tvalid; the CRC
// compare and field decode fit in the cycle that loads the output register.
// A stalled result holds the output register; the back keeps taking frame
// bytes and waits only at the next frame's last byte, and s_tready drops
// once the queue holds four frame bytes, that waiting last byte included.
// Synchronous reset returns to hunting; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sensor_frame_receiver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] left_speed, [31:16] right_speed, [39:32] battery_voltage,
  // [47:40] left_ir_a, [55:48] left_ir_b, [63:56] right_ir_a,
  // [71:64] right_ir_b, [103:72] left_odometry, [135:104] right_odometry,
  // [143:136] motor_current, [151:144] firmware_version
  output logic [151:0] m_tdata,
  output logic         m_tuser    // [0] frame_status
);
  import srx_pkg::*;

  logic          push;
  logic          pop;
  item_t         push_item;
  item_t         head;
  queue_status_t q_status;

  srx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  srx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  srx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sensor_frame_receiver. Serial bytes are sent over the s_*
// stream, framed with sync bytes, carrying correct or broken CRC-16/MODBUS
// trailers. A local frame decoder predicts every decoded frame, and each
// transaction on the m_* stream is checked against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srx_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef logic [7:0] frame_body_t [CRC_LEN];

  typedef struct {
    frame_fields_t fields;
    logic          status;
  } decoded_frame_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;
  logic         m_tuser;

  // Decoder state mirrored from the block
  logic        rx_collecting;
  int          rx_pos;
  logic [15:0] rx_crc;
  logic [7:0]  rx_buf [FRAME_LEN];

  decoded_frame_t pending_frames[$];

  int src_idle_pct;
  int sink_idle_pct;
  int bytes_sent;
  int fail_count;
  int cycle_count;

  sensor_frame_receiver uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Bit-serial reflected CRC-16, lowest input bit first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  // Advance the frame decoder by one accepted byte; queue a frame when complete
  task automatic decode_byte(input logic [7:0] b);
    decoded_frame_t df;
    if (!rx_collecting) begin
      if (b == SYNC_BYTE) begin
        rx_collecting = 1'b1;
        rx_pos        = 0;
        rx_crc        = CRC_INIT;
      end
      return;
    end
    if (rx_pos >= FRAME_LEN) begin
      rx_collecting = 1'b0;
      rx_pos        = 0;
      return;
    end
    rx_buf[rx_pos] = b;
    if (rx_pos < CRC_LEN) begin
      rx_crc = crc16_step(rx_crc, b);
    end
    if (rx_pos < FRAME_LEN - 1) begin
      rx_pos++;
      return;
    end
    rx_collecting = 1'b0;
    rx_pos        = 0;
    df.fields     = '0;
    df.status     = 1'b1;
    if ({rx_buf[20], rx_buf[19]} == rx_crc) begin
      df.status                  = 1'b0;
      df.fields.left_speed       = {rx_buf[1], rx_buf[0]};
      df.fields.right_speed      = {rx_buf[10], rx_buf[9]};
      df.fields.battery_voltage  = rx_buf[2];
      df.fields.left_ir_a        = rx_buf[3];
      df.fields.left_ir_b        = rx_buf[4];
      df.fields.right_ir_a       = rx_buf[11];
      df.fields.right_ir_b       = rx_buf[12];
      df.fields.left_odometry    = {rx_buf[8], rx_buf[7], rx_buf[6], rx_buf[5]};
      df.fields.right_odometry   = {rx_buf[16], rx_buf[15], rx_buf[14], rx_buf[13]};
      df.fields.motor_current    = rx_buf[17];
      df.fields.firmware_version = rx_buf[18];
    end
    pending_frames.push_back(df);
  endtask

  // Send one byte, with random gaps ahead of it, and record it once accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do begin
      @(posedge clk);
    end while (!s_tready);
    bytes_sent++;
    decode_byte(b);
  endtask

  // Send sync, body and CRC trailer; a bad frame has one bit flipped
  task automatic send_frame(input frame_body_t body, input bit good);
    logic [15:0] crc;
    logic [15:0] trailer;
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_step(crc, body[i]);
    end
    trailer = crc;
    if (!good) begin
      if ($urandom_range(1)) begin
        trailer = trailer ^ (16'h0001 << $urandom_range(15));
      end else begin
        body[$urandom_range(CRC_LEN - 1)] ^= 8'h01 << $urandom_range(7);
      end
    end
    send_byte(SYNC_BYTE);
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(trailer[7:0]);
    send_byte(trailer[15:8]);
  endtask

  // Random body, biased towards all-zero and all-one bytes
  function automatic frame_body_t random_body();
    frame_body_t body;
    int pick;
    foreach (body[i]) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        body[i] = 8'h00;
      end else if (pick < 15) begin
        body[i] = 8'hFF;
      end else begin
        body[i] = 8'($urandom_range(255));
      end
    end
    return body;
  endfunction

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(254)));
    end
  endtask

  // Mostly well-formed frames; some broken ones and some line noise
  task automatic run_random(input int n_bytes);
    int target;
    int pick;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_frame(random_body(), 1'b1);
      end else if (pick < 92) begin
        send_frame(random_body(), 1'b0);
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
  endtask

  // Field extremes, sync inside a frame, CRC mismatch and the resync after it
  task automatic test_directed();
    frame_body_t body;
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'h7F);
    send_byte(8'h80);
    foreach (body[i]) begin
      body[i] = 8'hFF;
    end
    send_frame(body, 1'b1);
    foreach (body[i]) begin
      body[i] = 8'h00;
    end
    body[0]  = 8'hFF;
    body[1]  = 8'h7F;
    body[10] = 8'h80;
    send_frame(body, 1'b1);
    send_frame(body, 1'b0);
    body[1]  = 8'h80;
    body[0]  = 8'h00;
    body[9]  = 8'hFF;
    body[10] = 8'h7F;
    body[8]  = 8'h80;
    body[16] = 8'h80;
    send_frame(body, 1'b1);
  endtask

  task automatic test_sender_gaps();
    src_idle_pct  = 28;
    sink_idle_pct = 48;
    run_random(460);
  endtask

  task automatic test_receiver_gaps();
    src_idle_pct  = 48;
    sink_idle_pct = 28;
    run_random(460);
  endtask

  task automatic test_full_rate();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(460);
  endtask

  function automatic bit field_ok(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Stall the result stream at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Check each result transaction against the oldest decoded frame
  always @(posedge clk) begin : result_check
    decoded_frame_t want;
    frame_fields_t  got;
    bit             ok;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("result transaction with no frame pending");
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        got  = m_tdata;
        ok   = 1'b1;
        ok &= field_ok("left_speed", longint'($signed(want.fields.left_speed)),
                       longint'($signed(got.left_speed)));
        ok &= field_ok("right_speed", longint'($signed(want.fields.right_speed)),
                       longint'($signed(got.right_speed)));
        ok &= field_ok("battery_voltage", want.fields.battery_voltage, got.battery_voltage);
        ok &= field_ok("left_ir_a", want.fields.left_ir_a, got.left_ir_a);
        ok &= field_ok("left_ir_b", want.fields.left_ir_b, got.left_ir_b);
        ok &= field_ok("right_ir_a", want.fields.right_ir_a, got.right_ir_a);
        ok &= field_ok("right_ir_b", want.fields.right_ir_b, got.right_ir_b);
        ok &= field_ok("left_odometry", want.fields.left_odometry, got.left_odometry);
        ok &= field_ok("right_odometry", want.fields.right_odometry, got.right_odometry);
        ok &= field_ok("motor_current", want.fields.motor_current, got.motor_current);
        ok &= field_ok("firmware_version", want.fields.firmware_version,
                       got.firmware_version);
        ok &= field_ok("frame_status", want.status, m_tuser);
        if (!ok) begin
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sensor_frame_receiver");
      $finish;
    end
  end

  initial begin
    rx_collecting = 1'b0;
    rx_pos        = 0;
    rx_crc        = CRC_INIT;
    src_idle_pct  = 28;
    sink_idle_pct = 48;
    bytes_sent    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_sender_gaps();
    test_receiver_gaps();
    test_full_rate();

    // Drain outstanding frames, then allow for any stray output
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS sensor_frame_receiver");
    end else begin
      $display("FAIL sensor_frame_receiver");
    end
    $finish;
  end

endmodule

### files.f
rtl/srx_pkg.sv
rtl/srx_front.sv
rtl/srx_queue.sv
rtl/srx_back.sv
rtl/sensor_frame_receiver.sv
test/tb_top.sv
